// ===== sv/gotm_pkg.sv =====
// gotm_pkg: shared constants, types and fixed-point helpers for gps_offset_to_meters.
// Used by gotm_sincos, gotm_arc and the top level; depends on nothing else.
package gotm_pkg;

    localparam int CORDIC_ITER = 32;
    localparam int ANG_W       = 33;
    localparam int ROT_W       = 34;
    localparam int MAG_W       = 31;
    localparam int RAD_W       = 33;
    localparam int DIST_W      = 35;
    localparam int SQ_W        = 62;
    localparam int ROOT_W      = 31;

    localparam logic [30:0]        DEG7_MUL        = 31'd2012227627;
    localparam logic signed [32:0] PI_Q29          = 33'sd1686629713;
    localparam logic [30:0]        HALF_PI_Q29     = 31'd843314857;
    localparam logic signed [33:0] INV_GAIN_Q30    = 34'sd652032874;
    localparam logic [30:0]        ONE_Q30         = 31'h4000_0000;
    localparam logic [32:0]        RADIUS_MM_RESET = 33'd6371000000;

    typedef struct packed {
        logic neg_east;
        logic neg_north;
    } sign_t;

    // atan(2^-i) in Q29, rounded to nearest
    function automatic logic [28:0] atan_q29(input int unsigned i);
        logic [28:0] v;
        case (i)
            0:       v = 29'd421657428;
            1:       v = 29'd248918915;
            2:       v = 29'd131521918;
            3:       v = 29'd66762579;
            4:       v = 29'd33510843;
            5:       v = 29'd16771758;
            6:       v = 29'd8387925;
            7:       v = 29'd4194219;
            8:       v = 29'd2097141;
            9:       v = 29'd1048575;
            default:
            begin
                if (i < 30)
                begin
                    v = 29'(1) << (29 - i);
                end
                else if (i == 30)
                begin
                    v = 29'd1;
                end
                else
                begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [30:0] clamp_q30(input logic signed [33:0] v);
        logic [33:0] m;
        m = v[33] ? 34'(-v) : 34'(v);
        return (m > 34'(ONE_Q30)) ? ONE_Q30 : m[30:0];
    endfunction

    function automatic logic [30:0] qmul30(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + (62'(1) << 29);
        return p[60:30];
    endfunction

endpackage

// ===== sv/gotm_sincos.sv =====
// gotm_sincos: pipelined rotation CORDIC giving |cos| and |sin| of a Q29 angle in Q30.
// Depends on gotm_pkg. Takes one angle per cycle.
module gotm_sincos (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [30:0]         th,
    input  gotm_pkg::sign_t     in_sign,
    output logic                out_valid,
    output logic [30:0]         cos_mag,
    output logic [30:0]         sin_mag,
    output gotm_pkg::sign_t     out_sign
);

    localparam int N  = gotm_pkg::CORDIC_ITER;
    localparam int AW = gotm_pkg::ANG_W;
    localparam int RW = gotm_pkg::ROT_W;

    logic [N+1:0]             vld_reg;
    gotm_pkg::sign_t          sg_reg [0:N+1];
    logic signed [RW-1:0]     x_reg  [0:N];
    logic signed [RW-1:0]     y_reg  [0:N];
    logic signed [AW-1:0]     z_reg  [0:N];
    logic signed [RW-1:0]     x_next [1:N];
    logic signed [RW-1:0]     y_next [1:N];
    logic signed [AW-1:0]     z_next [1:N];
    logic signed [AW-1:0]     z0_next;
    logic [30:0]              cos_reg;
    logic [30:0]              sin_reg;

    // fold angles above pi/2 back below it
    always_comb
    begin
        if (th > gotm_pkg::HALF_PI_Q29)
        begin
            z0_next = gotm_pkg::PI_Q29 - $signed(AW'(th));
        end
        else
        begin
            z0_next = $signed(AW'(th));
        end
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (!z_reg[i][AW-1])
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - $signed(AW'(gotm_pkg::atan_q29(i)));
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + $signed(AW'(gotm_pkg::atan_q29(i)));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[N:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        sg_reg[0] <= in_sign;
        x_reg[0]  <= gotm_pkg::INV_GAIN_Q30;
        y_reg[0]  <= '0;
        z_reg[0]  <= z0_next;
        for (int i = 0; i < N; i++)
        begin
            x_reg[i+1] <= x_next[i+1];
            y_reg[i+1] <= y_next[i+1];
            z_reg[i+1] <= z_next[i+1];
        end
        for (int i = 0; i <= N; i++)
        begin
            sg_reg[i+1] <= sg_reg[i];
        end
        cos_reg <= gotm_pkg::clamp_q30(x_reg[N]);
        sin_reg <= gotm_pkg::clamp_q30(y_reg[N]);
    end

    assign out_valid = vld_reg[N+1];
    assign out_sign  = sg_reg[N+1];
    assign cos_mag   = cos_reg;
    assign sin_mag   = sin_reg;

endmodule

// ===== sv/gotm_arc.sv =====
// gotm_arc: haversine term a (Q30) to arc length in mm: two digit-serial square roots,
// pipelined vectoring CORDIC, radius scaling. Depends on gotm_pkg.
module gotm_arc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [30:0]         a,
    input  logic [32:0]         radius_mm,
    input  gotm_pkg::sign_t     in_sign,
    output logic                out_valid,
    output logic [34:0]         mag,
    output gotm_pkg::sign_t     out_sign
);

    localparam int N   = gotm_pkg::CORDIC_ITER;
    localparam int AW  = gotm_pkg::ANG_W;
    localparam int RW  = gotm_pkg::ROT_W;
    localparam int QW  = gotm_pkg::SQ_W;
    localparam int SW  = gotm_pkg::ROOT_W;
    localparam int DW  = gotm_pkg::DIST_W;
    localparam int LAT = SW + N + 4;

    logic [LAT-1:0]           vld_reg;
    gotm_pkg::sign_t          sg_reg [0:LAT-1];

    logic [QW-1:0]            ra_reg  [0:SW];
    logic [QW-1:0]            rb_reg  [0:SW];
    logic [SW-1:0]            qa_reg  [0:SW];
    logic [SW-1:0]            qb_reg  [0:SW];
    logic [QW-1:0]            ra_next [1:SW];
    logic [QW-1:0]            rb_next [1:SW];
    logic [SW-1:0]            qa_next [1:SW];
    logic [SW-1:0]            qb_next [1:SW];

    logic signed [RW-1:0]     vx_reg  [0:N];
    logic signed [RW-1:0]     vy_reg  [0:N];
    logic signed [AW-1:0]     vz_reg  [0:N];
    logic signed [RW-1:0]     vx_next [1:N];
    logic signed [RW-1:0]     vy_next [1:N];
    logic signed [AW-1:0]     vz_next [1:N];

    logic [29:0]              zc;
    logic [63:0]              prod_reg;
    logic [DW-1:0]            mag_reg;
    logic [63:0]              rnd;

    // one root bit per stage, most significant first
    always_comb
    begin
        logic [QW-1:0] ta;
        logic [QW-1:0] tb;
        for (int j = 0; j < SW; j++)
        begin
            ta = (QW'(qa_reg[j]) << (SW - j)) | (QW'(1) << (2 * (SW - 1 - j)));
            tb = (QW'(qb_reg[j]) << (SW - j)) | (QW'(1) << (2 * (SW - 1 - j)));
            if (ra_reg[j] >= ta)
            begin
                ra_next[j+1] = ra_reg[j] - ta;
                qa_next[j+1] = qa_reg[j] | (SW'(1) << (SW - 1 - j));
            end
            else
            begin
                ra_next[j+1] = ra_reg[j];
                qa_next[j+1] = qa_reg[j];
            end
            if (rb_reg[j] >= tb)
            begin
                rb_next[j+1] = rb_reg[j] - tb;
                qb_next[j+1] = qb_reg[j] | (SW'(1) << (SW - 1 - j));
            end
            else
            begin
                rb_next[j+1] = rb_reg[j];
                qb_next[j+1] = qb_reg[j];
            end
        end
    end

    // drive y toward zero; both roots zero ends negative and clamps to zero
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (!vy_reg[i][RW-1] && (vy_reg[i] != '0))
            begin
                vx_next[i+1] = vx_reg[i] + (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] - (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] + $signed(AW'(gotm_pkg::atan_q29(i)));
            end
            else
            begin
                vx_next[i+1] = vx_reg[i] - (vy_reg[i] >>> i);
                vy_next[i+1] = vy_reg[i] + (vx_reg[i] >>> i);
                vz_next[i+1] = vz_reg[i] - $signed(AW'(gotm_pkg::atan_q29(i)));
            end
        end
    end

    assign zc  = vz_reg[N][AW-1] ? '0 : vz_reg[N][29:0];
    assign rnd = prod_reg + (64'(1) << 28);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        sg_reg[0] <= in_sign;
        for (int i = 1; i < LAT; i++)
        begin
            sg_reg[i] <= sg_reg[i-1];
        end

        ra_reg[0] <= QW'(a) << 30;
        rb_reg[0] <= QW'(gotm_pkg::ONE_Q30 - a) << 30;
        qa_reg[0] <= '0;
        qb_reg[0] <= '0;
        for (int j = 0; j < SW; j++)
        begin
            ra_reg[j+1] <= ra_next[j+1];
            rb_reg[j+1] <= rb_next[j+1];
            qa_reg[j+1] <= qa_next[j+1];
            qb_reg[j+1] <= qb_next[j+1];
        end

        vx_reg[0] <= $signed(RW'(qb_reg[SW]));
        vy_reg[0] <= $signed(RW'(qa_reg[SW]));
        vz_reg[0] <= '0;
        for (int i = 0; i < N; i++)
        begin
            vx_reg[i+1] <= vx_next[i+1];
            vy_reg[i+1] <= vy_next[i+1];
            vz_reg[i+1] <= vz_next[i+1];
        end

        prod_reg <= 64'(radius_mm) * 64'({zc, 1'b0});
        mag_reg  <= rnd[63:29];
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_sign  = sg_reg[LAT-1];
    assign mag       = mag_reg;

endmodule

// ===== sv/gps_offset_to_meters.sv =====
// gps_offset_to_meters: top level, east/north offsets in mm from two lat/lon positions.
// Depends on gotm_pkg, gotm_sincos and gotm_arc.
//
// Usage:
//   Drive pos_lat, pos_lon, ref_lat, ref_lon (1e-7 degree) and pulse start. busy is
//   always low: the datapath is a fully pipelined chain of CORDIC and root stages, so
//   a transaction is taken on every cycle that start is high.
//   Each transaction returns one result: done is high for exactly one cycle with
//   east_mm and north_mm valid, at the end of a chain of 106 register stages. The
//   chain length is set by the two CORDIC chains (one stage per iteration each) and
//   the 31-stage square roots.
//   Throughput is one transaction per cycle; results leave in order.
//   The receiver cannot stall; done and the result ports are shown for one cycle only.
//   Write the earth radius in metres with cfg_we/cfg_wdata while no transaction is in
//   flight; it is stored scaled to millimetres.
//   Reset clears all valid bits (nothing in flight) and sets the radius to 6371000 m.
module gps_offset_to_meters (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [30:0]  pos_lat,
    input  logic signed [31:0]  pos_lon,
    input  logic signed [30:0]  ref_lat,
    input  logic signed [31:0]  ref_lon,
    input  logic                cfg_we,
    input  logic [22:0]         cfg_wdata,
    output logic                done,
    output logic signed [35:0]  east_mm,
    output logic signed [35:0]  north_mm
);

    localparam int RD = gotm_pkg::RAD_W;

    logic [RD-1:0]            radius_mm_reg;

    logic signed [32:0]       dlon;
    logic signed [31:0]       dlat;
    logic                     a_vld_reg;
    gotm_pkg::sign_t          a_sign_reg;
    logic [32:0]              mdlon_reg;
    logic [31:0]              mdlat_reg;
    logic [30:0]              mrlat_reg;

    logic [63:0]              plon;
    logic [63:0]              plat;
    logic [63:0]              pref;
    logic                     b_vld_reg;
    gotm_pkg::sign_t          b_sign_reg;
    logic [30:0]              hlon_reg;
    logic [30:0]              hlat_reg;
    logic [30:0]              flat_reg;

    logic                     sc_vld;
    gotm_pkg::sign_t          sc_sign;
    logic [30:0]              cos_ref;
    logic [30:0]              sin_lon;
    logic [30:0]              sin_lat;

    logic                     c_vld_reg;
    gotm_pkg::sign_t          c_sign_reg;
    logic [30:0]              cc_reg;
    logic [30:0]              ss_lon_reg;
    logic [30:0]              ss_lat_reg;

    logic                     d_vld_reg;
    gotm_pkg::sign_t          d_sign_reg;
    logic [30:0]              a_east_reg;
    logic [30:0]              a_north_reg;

    logic                     arc_vld;
    gotm_pkg::sign_t          arc_sign;
    logic [34:0]              east_mag;
    logic [34:0]              north_mag;

    logic                     done_reg;
    logic signed [35:0]       east_reg;
    logic signed [35:0]       north_reg;
    logic signed [35:0]       east_next;
    logic signed [35:0]       north_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_mm_reg <= gotm_pkg::RADIUS_MM_RESET;
        end
        else if (cfg_we)
        begin
            radius_mm_reg <= RD'(cfg_wdata) * RD'(1000);
        end
    end

    // stage A: differences and magnitudes
    assign dlon = 33'(pos_lon) - 33'(ref_lon);
    assign dlat = 32'(pos_lat) - 32'(ref_lat);

    // stage B: 1e-7 degree to Q29 radians; the two differences are halved
    assign plon = 64'(mdlon_reg) * 64'(gotm_pkg::DEG7_MUL) + (64'(1) << 31);
    assign plat = 64'(mdlat_reg) * 64'(gotm_pkg::DEG7_MUL) + (64'(1) << 31);
    assign pref = 64'(mrlat_reg) * 64'(gotm_pkg::DEG7_MUL) + (64'(1) << 30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start && !busy;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= sc_vld;
            d_vld_reg <= c_vld_reg;
            done_reg  <= arc_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sign_reg.neg_east  <= pos_lon < ref_lon;
        a_sign_reg.neg_north <= pos_lat < ref_lat;
        mdlon_reg <= dlon[32] ? 33'(-dlon) : 33'(dlon);
        mdlat_reg <= dlat[31] ? 32'(-dlat) : 32'(dlat);
        mrlat_reg <= ref_lat[30] ? 31'(-ref_lat) : 31'(ref_lat);

        b_sign_reg <= a_sign_reg;
        hlon_reg   <= plon[62:32];
        hlat_reg   <= plat[62:32];
        flat_reg   <= pref[61:31];

        c_sign_reg <= sc_sign;
        cc_reg     <= gotm_pkg::qmul30(cos_ref, cos_ref);
        ss_lon_reg <= gotm_pkg::qmul30(sin_lon, sin_lon);
        ss_lat_reg <= gotm_pkg::qmul30(sin_lat, sin_lat);

        d_sign_reg  <= c_sign_reg;
        a_east_reg  <= gotm_pkg::qmul30(cc_reg, ss_lon_reg);
        a_north_reg <= ss_lat_reg;

        east_reg  <= east_next;
        north_reg <= north_next;
    end

    gotm_sincos u_sc_ref (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_vld_reg),
        .th        (flat_reg),
        .in_sign   (b_sign_reg),
        .out_valid (sc_vld),
        .cos_mag   (cos_ref),
        .sin_mag   (),
        .out_sign  (sc_sign)
    );

    gotm_sincos u_sc_lon (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_vld_reg),
        .th        (hlon_reg),
        .in_sign   (b_sign_reg),
        .out_valid (),
        .cos_mag   (),
        .sin_mag   (sin_lon),
        .out_sign  ()
    );

    gotm_sincos u_sc_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_vld_reg),
        .th        (hlat_reg),
        .in_sign   (b_sign_reg),
        .out_valid (),
        .cos_mag   (),
        .sin_mag   (sin_lat),
        .out_sign  ()
    );

    gotm_arc u_arc_east (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_vld_reg),
        .a         (a_east_reg),
        .radius_mm (radius_mm_reg),
        .in_sign   (d_sign_reg),
        .out_valid (arc_vld),
        .mag       (east_mag),
        .out_sign  (arc_sign)
    );

    gotm_arc u_arc_north (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_vld_reg),
        .a         (a_north_reg),
        .radius_mm (radius_mm_reg),
        .in_sign   (d_sign_reg),
        .out_valid (),
        .mag       (north_mag),
        .out_sign  ()
    );

    // apply direction
    always_comb
    begin
        east_next  = arc_sign.neg_east  ? $signed(36'(0) - 36'(east_mag))
                                        : $signed(36'(east_mag));
        north_next = arc_sign.neg_north ? $signed(36'(0) - 36'(north_mag))
                                        : $signed(36'(north_mag));
    end

    assign done     = done_reg;
    assign east_mm  = east_reg;
    assign north_mm = north_reg;

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for gps_offset_to_meters, with its own offset predictor.
// Depends on gotm_pkg and the gps_offset_to_meters RTL; sends directed and random positions.
module testbench;

    localparam longint unsigned PI62 = 64'hC90FDAA22168C235;
    localparam longint PI29 = longint'((PI62 + (64'd1 << 32)) >> 33);
    localparam longint HALF_PI29 = longint'((PI62 + (64'd1 << 33)) >> 34);
    localparam longint unsigned DEG_SCALE = (PI62 + 64'd3600000000) / 64'd7200000000;
    localparam longint GAIN_INV = 652032874;
    localparam longint UNIT30 = longint'(1) << 30;
    localparam int LATENCY = 106;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [35:0] east;
        logic signed [35:0] north;
    } offset_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [30:0] pos_lat = '0;
    logic signed [31:0] pos_lon = '0;
    logic signed [30:0] ref_lat = '0;
    logic signed [31:0] ref_lon = '0;
    logic cfg_we = 1'b0;
    logic [22:0] cfg_wdata = '0;
    logic done;
    logic signed [35:0] east_mm;
    logic signed [35:0] north_mm;

    longint arctan_q29[gotm_pkg::CORDIC_ITER];
    longint unsigned radius_m = 6371000;
    offset_t pending_offsets[$];
    int errors = 0;
    int cycles = 0;
    bit steady = 1'b0;

    gps_offset_to_meters dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_lat(pos_lat), .pos_lon(pos_lon), .ref_lat(ref_lat), .ref_lon(ref_lon),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .done(done), .east_mm(east_mm), .north_mm(north_mm)
    );

    always #4 clk = ~clk;

    function automatic void build_arctan();
        longint s;
        longint unsigned m;
        longint unsigned p;
        longint term;
        for (int i = 0; i < gotm_pkg::CORDIC_ITER; i++)
        begin
            if (i == 0)
            begin
                arctan_q29[i] = longint'((PI62 + (64'd1 << 34)) >> 35);
            end
            else
            begin
                s = 0;
                for (int k = 0; ; k++)
                begin
                    m = 2 * k + 1;
                    p = i * m;
                    if (p > 62)
                        break;
                    term = longint'((64'd1 << (62 - p)) / m);
                    if (k % 2 == 1)
                        s -= term;
                    else
                        s += term;
                end
                arctan_q29[i] = (s + (longint'(1) << 32)) >>> 33;
            end
        end
    endfunction

    function automatic longint mag_q30(longint v);
        if (v < 0)
            v = -v;
        return (v > UNIT30) ? UNIT30 : v;
    endfunction

    function automatic void rotate(longint th, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = GAIN_INV;
        y = 0;
        z = th;
        if (z > HALF_PI29)
            z = PI29 - z;
        for (int i = 0; i < gotm_pkg::CORDIC_ITER; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_q29[i];
            end
            else
            begin
                x += dx; y -= dy; z += arctan_q29[i];
            end
        end
        c = mag_q30(x);
        s = mag_q30(y);
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic longint unsigned arc_length_mm(longint a);
        longint y;
        longint x;
        longint z;
        longint dx;
        longint dy;
        if (a < 0)
            a = 0;
        if (a > UNIT30)
            a = UNIT30;
        y = longint'(floor_root(longint'(a) << 30));
        x = longint'(floor_root(longint'(UNIT30 - a) << 30));
        z = 0;
        if (x != 0 || y != 0)
        begin
            for (int i = 0; i < gotm_pkg::CORDIC_ITER; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x += dx; y -= dy; z += arctan_q29[i];
                end
                else
                begin
                    x -= dx; y += dy; z -= arctan_q29[i];
                end
            end
            if (z < 0)
                z = 0;
        end
        return (radius_m * 1000 * longint'(2 * z) + (64'd1 << 28)) >> 29;
    endfunction

    function automatic offset_t predict_offset(longint plat, longint plon, longint rlat,
                                               longint rlon);
        offset_t o;
        longint unsigned mdlon;
        longint unsigned mdlat;
        longint unsigned mrlat;
        longint hlon;
        longint hlat;
        longint flat;
        longint cr;
        longint sr;
        longint ch;
        longint sh;
        logic [35:0] d;
        mdlon = (plon >= rlon) ? plon - rlon : rlon - plon;
        mdlat = (plat >= rlat) ? plat - rlat : rlat - plat;
        mrlat = (rlat >= 0) ? rlat : -rlat;
        hlon = longint'((mdlon * DEG_SCALE + (64'd1 << 31)) >> 32);
        hlat = longint'((mdlat * DEG_SCALE + (64'd1 << 31)) >> 32);
        flat = longint'((mrlat * DEG_SCALE + (64'd1 << 30)) >> 31);
        rotate(flat, cr, sr);
        rotate(hlon, ch, sh);
        d = 36'(arc_length_mm(mul_q30(mul_q30(cr, cr), mul_q30(sh, sh))));
        o.east = (plon < rlon) ? -d : d;
        rotate(hlat, ch, sh);
        d = 36'(arc_length_mm(mul_q30(sh, sh)));
        o.north = (plat < rlat) ? -d : d;
        return o;
    endfunction

    task automatic send_position(logic signed [30:0] plat, logic signed [31:0] plon,
                                 logic signed [30:0] rlat, logic signed [31:0] rlon);
        if (!steady && $urandom_range(99) < 8)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        pos_lat <= plat;
        pos_lon <= plon;
        ref_lat <= rlat;
        ref_lon <= rlon;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_offsets.push_back(predict_offset(plat, plon, rlat, rlon));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_offsets.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic set_radius(logic [22:0] r);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
        radius_m = r;
    endtask

    function automatic logic signed [30:0] any_lat();
        case ($urandom_range(2))
            0: return 31'($urandom);
            default: return 31'(longint'($urandom_range(1800000000)) - 900000000);
        endcase
    endfunction

    function automatic logic signed [31:0] any_lon();
        case ($urandom_range(2))
            0: return 32'($urandom);
            default: return 32'(longint'($urandom_range(32'd3600000000)) - 1800000000);
        endcase
    endfunction

    task automatic test_directed();
        send_position(0, 0, 0, 0);
        send_position(123456789, -987654321, 123456789, -987654321);
        send_position(900000000, 1800000000, -900000000, -1800000000);
        send_position(-900000000, -1800000000, 900000000, 1800000000);
        send_position(31'sh3FFF_FFFF, 32'sh7FFF_FFFF, 31'sh4000_0000, 32'sh8000_0000);
        send_position(31'sh4000_0000, 32'sh8000_0000, 31'sh3FFF_FFFF, 32'sh7FFF_FFFF);
        send_position(1, 1, 0, 0);
        send_position(-1, -1, 0, 0);
        send_position(0, 10, 900000000, 0);
        send_position(0, 10, -900000000, 0);
        send_position(-900000000, 0, 900000000, 0);
        send_position(0, 1800000000, 0, 0);
        send_position(500000000, -1800000000, 499990000, -1799990000);
        send_position(-450000000, 900000000, -450001000, 900001000);
        drain();
    endtask

    task automatic test_radius_extremes();
        set_radius(23'd0);
        send_position(300000000, 1000000000, -200000000, -500000000);
        send_position(-900000000, 1800000000, 900000000, -1800000000);
        set_radius(23'h7F_FFFF);
        send_position(300000000, 1000000000, -200000000, -500000000);
        send_position(-900000000, 1800000000, 900000000, -1800000000);
        send_position(31'sh3FFF_FFFF, 32'sh7FFF_FFFF, 31'sh4000_0000, 32'sh8000_0000);
    endtask

    task automatic test_random(int count);
        logic signed [30:0] rlat;
        logic signed [31:0] rlon;
        for (int n = 0; n < count; n++)
        begin
            steady = (n >= count / 3) && (n < count / 2);
            rlat = any_lat();
            rlon = any_lon();
            if ($urandom_range(99) < 70)
                send_position(31'(longint'(rlat) + $urandom_range(400000) - 200000),
                              32'(longint'(rlon) + $urandom_range(400000) - 200000),
                              rlat, rlon);
            else
                send_position(any_lat(), any_lon(), rlat, rlon);
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        offset_t exp_off;
        if (rst_n && done)
        begin
            if (pending_offsets.size() == 0)
            begin
                $display("%0t: unexpected result east %0d north %0d", $time, east_mm, north_mm);
                errors++;
            end
            else
            begin
                exp_off = pending_offsets.pop_front();
                if (east_mm !== exp_off.east)
                begin
                    $display("%0t: east_mm expected %0d actual %0d", $time, exp_off.east,
                             east_mm);
                    errors++;
                end
                if (north_mm !== exp_off.north)
                begin
                    $display("%0t: north_mm expected %0d actual %0d", $time, exp_off.north,
                             north_mm);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        build_arctan();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_radius_extremes();
        set_radius(23'd6300000);
        test_random(400);
        set_radius(23'd6400000);
        test_random(400);
        set_radius(23'd6371000);
        test_random(400);
        set_radius(23'($urandom_range(6300000, 6400000)));
        test_random(130);
        drain();
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
